@@ src/lr1tp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr1tp_pkg
// Shared types and codes of the table-driven LR(1) recognizer.
// ----------------------------------------------------------------------------
package lr1tp_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        MODE_TABLE = 2'd0,
        MODE_RULE  = 2'd1,
        MODE_START = 2'd2,
        MODE_TOKEN = 2'd3
    } mode_t;

    // action table entry kinds
    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_SHIFT   = 2'd1,
        KIND_REDUCE  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [3:0] {
        ST_ACK       = 4'd0,
        ST_SHIFT     = 4'd1,
        ST_REDUCE    = 4'd2,
        ST_ACCEPT    = 4'd3,
        ST_NO_TRANS  = 4'd4,
        ST_BAD_STATE = 4'd5,
        ST_BAD_RULE  = 4'd6,
        ST_MISMATCH  = 4'd7,
        ST_UNKNOWN   = 4'd8,
        ST_LIMIT     = 4'd9,
        ST_ENDED     = 4'd10
    } status_t;

    // parse progress
    typedef enum logic [1:0] {
        PS_IDLE   = 2'd0,
        PS_ACTIVE = 2'd1,
        PS_DONE   = 2'd2
    } pstat_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PROC,
        S_LOOK,
        S_RLEN,
        S_POP,
        S_POPCMP,
        S_GOTOST,
        S_GOTOLK,
        S_EMIT
    } fsm_t;

    // register indexes
    localparam logic [1:0] REG_BEGIN = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_SCNT  = 2'd2;
    localparam logic [1:0] REG_RCNT  = 2'd3;

    typedef struct packed {
        mode_t       mode;
        logic [8:0]  row;
        logic [10:0] symbol;
        logic [1:0]  action_kind;
        logic [8:0]  target;
        logic [4:0]  rule_pos;
        logic [4:0]  rule_length;
        logic        last_token;
    } item_t;

    typedef struct packed {
        logic [10:0] begin_symbol;
        logic [10:0] end_symbol;
        logic [8:0]  state_count;
        logic [9:0]  rule_count;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [8:0]  rule_number;
        logic [10:0] lhs_symbol;
        logic [7:0]  state_now;
        logic        last;
    } res_t;

endpackage

@@ src/lr1tp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr1tp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lr1tp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lr1tp_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr1tp_engine
// Sequencer and memories: table/rule loads, shift, reduce pops and goto.
// ----------------------------------------------------------------------------
module lr1tp_engine #(
    parameter int NUM_STATES     = 256,
    parameter int NUM_SYMBOLS    = 2048,
    parameter int NUM_RULES      = 512,
    parameter int MAX_RULE_LEN   = 16,
    parameter int STACK_DEPTH    = 256,
    parameter int MAX_REDUCTIONS = 63
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lr1tp_pkg::item_t in_item,
    input  lr1tp_pkg::cfg_t  cfg,
    output logic           res_valid,
    input  logic           res_ready,
    output lr1tp_pkg::res_t  res
);
    import lr1tp_pkg::*;

    localparam int STW    = ($clog2(NUM_STATES) > 9) ? 9 : $clog2(NUM_STATES);
    localparam int TDEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int STRIDE = MAX_RULE_LEN + 1;
    localparam int RDEPTH = NUM_RULES * STRIDE;
    localparam int RAW    = $clog2(RDEPTH);
    localparam int LAW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int SEW    = STW + 11;
    localparam int KW     = $clog2(MAX_RULE_LEN + 1);
    localparam int RDW    = $clog2(MAX_REDUCTIONS + 1);

    // state
    fsm_t              state_reg, state_next, ret_reg, ret_next;
    item_t             item_reg, item_next;
    pstat_t            pstat_reg, pstat_next;
    res_t              res_reg, res_next;
    logic [TAW-1:0]    clr_reg, clr_next;
    logic [10:0]       sym_reg, sym_next;
    logic              is_end_reg, is_end_next;
    logic              oob_reg, oob_next;
    logic [RDW-1:0]    red_reg, red_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [STW-1:0]    cs_reg, cs_next;
    logic [8:0]        rule_reg, rule_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [10:0]       lhs_reg, lhs_next;

    // memory ports
    logic              tbl_we;
    logic [TAW-1:0]    tbl_waddr, tbl_raddr;
    logic [10:0]       tbl_wdata, tbl_rdata;
    logic              rs_we;
    logic [RAW-1:0]    rs_waddr, rs_raddr;
    logic [10:0]       rs_rdata;
    logic              rl_we;
    logic [LAW-1:0]    rl_waddr, rl_raddr;
    logic [4:0]        rl_rdata;
    logic              stk_we;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [SEW-1:0]    stk_wdata, stk_rdata;

    logic [12:0]       lim, rlim;
    logic [SPW-1:0]    spm1;

    assign lim  = (13'(cfg.state_count) < 13'(NUM_STATES)) ? 13'(cfg.state_count)
                                                             : 13'(NUM_STATES);
    assign rlim = (13'(cfg.rule_count) < 13'(NUM_RULES)) ? 13'(cfg.rule_count)
                                                           : 13'(NUM_RULES);
    assign spm1 = sp_reg - SPW'(1);

    function automatic logic [TAW-1:0] tbl_addr(input logic [STW-1:0] st,
                                                input logic [10:0] sy);
        return TAW'(TAW'(st) * TAW'(NUM_SYMBOLS) + TAW'(sy));
    endfunction

    function automatic logic [RAW-1:0] rs_addr(input logic [8:0] r,
                                               input logic [6:0] p);
        return RAW'(RAW'(r) * RAW'(STRIDE) + RAW'(p));
    endfunction

    function automatic res_t mk_res(input status_t s, input logic [8:0] r,
                                    input logic [10:0] l, input logic [STW-1:0] st,
                                    input logic lst);
        res_t o;
        logic [8:0] st9;
        st9 = 9'(st);
        o.status      = s;
        o.rule_number = r;
        o.lhs_symbol  = l;
        o.state_now   = st9[7:0];
        o.last        = lst;
        return o;
    endfunction

    // memories
    lr1tp_ram #(.WIDTH(11), .DEPTH(TDEPTH)) u_tbl (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata(tbl_rdata)
    );
    lr1tp_ram #(.WIDTH(11), .DEPTH(RDEPTH)) u_rsym (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(in_item.symbol),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );
    lr1tp_ram #(.WIDTH(5), .DEPTH(NUM_RULES)) u_rlen (
        .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(in_item.rule_length),
        .raddr(rl_raddr), .rdata(rl_rdata)
    );
    lr1tp_ram #(.WIDTH(SEW), .DEPTH(STACK_DEPTH)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
            pstat_reg <= PS_IDLE;
            clr_reg   <= '0;
            sp_reg    <= '0;
            cs_reg    <= '0;
            red_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pstat_reg <= pstat_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            cs_reg    <= cs_next;
            red_reg   <= red_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        sym_reg    <= sym_next;
        is_end_reg <= is_end_next;
        oob_reg    <= oob_next;
        rule_reg   <= rule_next;
        k_reg      <= k_next;
        lhs_reg    <= lhs_next;
    end

    // sequencer
    always_comb
    begin
        logic [10:0]    e;
        logic [8:0]     tgt;
        logic [RDW-1:0] cap;
        logic [STW-1:0] pst;

        state_next  = state_reg;
        ret_next    = ret_reg;
        pstat_next  = pstat_reg;
        clr_next    = clr_reg;
        sp_next     = sp_reg;
        cs_next     = cs_reg;
        red_next    = red_reg;
        item_next   = item_reg;
        res_next    = res_reg;
        sym_next    = sym_reg;
        is_end_next = is_end_reg;
        oob_next    = oob_reg;
        rule_next   = rule_reg;
        k_next      = k_reg;
        lhs_next    = lhs_reg;

        tbl_we    = 1'b0;
        tbl_waddr = clr_reg;
        tbl_wdata = '0;
        tbl_raddr = tbl_addr(cs_reg, sym_reg);
        rs_we     = 1'b0;
        rs_waddr  = rs_addr(in_item.row, 7'(in_item.rule_pos));
        rs_raddr  = rs_addr(rule_reg, 7'(k_reg));
        rl_we     = 1'b0;
        rl_waddr  = LAW'(in_item.row);
        rl_raddr  = LAW'(rule_reg);
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = '0;
        stk_raddr = spm1[SAW-1:0];

        in_ready  = 1'b0;
        res_valid = 1'b0;

        e   = oob_reg ? 11'd0 : tbl_rdata;
        tgt = e[8:0];
        cap = item_reg.last_token ? RDW'(MAX_REDUCTIONS - 1) : RDW'(MAX_REDUCTIONS);
        pst = stk_rdata[SEW-1:11];

        case (state_reg)
            // sweep the action table to empty after reset
            S_CLEAR:
            begin
                tbl_we   = 1'b1;
                clr_next = clr_reg + TAW'(1);
                if (clr_reg == TAW'(TDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next   = in_item;
                    red_next    = '0;
                    is_end_next = 1'b0;
                    ret_next    = S_IDLE;
                    res_next    = mk_res(ST_ACK, '0, '0, cs_reg, 1'b1);
                    case (in_item.mode)
                        MODE_TABLE:
                        begin
                            tbl_we    = (int'(in_item.row) < NUM_STATES) &&
                                        (int'(in_item.symbol) < NUM_SYMBOLS);
                            tbl_waddr = tbl_addr(STW'(in_item.row), in_item.symbol);
                            tbl_wdata = {in_item.action_kind, in_item.target};
                            state_next = S_EMIT;
                        end
                        MODE_RULE:
                        begin
                            rs_we = (int'(in_item.row) < NUM_RULES) &&
                                    (int'(in_item.rule_pos) <= MAX_RULE_LEN) &&
                                    (int'(in_item.rule_length) <= MAX_RULE_LEN);
                            rl_we = rs_we;
                            state_next = S_EMIT;
                        end
                        MODE_START:
                        begin
                            stk_we     = 1'b1;
                            stk_waddr  = '0;
                            sp_next    = SPW'(1);
                            cs_next    = '0;
                            pstat_next = PS_ACTIVE;
                            sym_next   = cfg.begin_symbol;
                            state_next = S_PROC;
                        end
                        default:
                        begin
                            if (pstat_reg != PS_ACTIVE)
                            begin
                                res_next   = mk_res(ST_ENDED, '0, '0, cs_reg, 1'b1);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                sym_next   = in_item.symbol;
                                state_next = S_PROC;
                            end
                        end
                    endcase
                end
            end

            // check state, issue lookup for the lookahead
            S_PROC:
            begin
                oob_next = (int'(sym_reg) >= NUM_SYMBOLS);
                if (13'(cs_reg) >= lim)
                begin
                    res_next   = mk_res(ST_BAD_STATE, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                case (kind_t'(e[10:9]))
                    KIND_EMPTY:
                    begin
                        res_next   = mk_res(ST_NO_TRANS, '0, '0, cs_reg, 1'b1);
                        pstat_next = PS_DONE;
                    end
                    KIND_UNKNOWN:
                    begin
                        res_next   = mk_res(ST_UNKNOWN, '0, '0, cs_reg, 1'b1);
                        pstat_next = PS_DONE;
                    end
                    KIND_SHIFT:
                    begin
                        if (13'(tgt) >= lim)
                        begin
                            res_next   = mk_res(ST_BAD_STATE, '0, '0, cs_reg, 1'b1);
                            pstat_next = PS_DONE;
                        end
                        else if (int'(sp_reg) >= STACK_DEPTH)
                        begin
                            res_next   = mk_res(ST_LIMIT, '0, '0, cs_reg, 1'b1);
                            pstat_next = PS_DONE;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = {STW'(tgt), sym_reg};
                            sp_next   = sp_reg + SPW'(1);
                            cs_next   = STW'(tgt);
                            res_next  = mk_res(is_end_reg ? ST_ACCEPT : ST_SHIFT, '0, '0,
                                               STW'(tgt),
                                               is_end_reg || !item_reg.last_token);
                            if (is_end_reg)
                            begin
                                pstat_next = PS_DONE;
                            end
                            else if (item_reg.last_token)
                            begin
                                sym_next    = cfg.end_symbol;
                                is_end_next = 1'b1;
                                ret_next    = S_PROC;
                            end
                        end
                    end
                    default:
                    begin
                        if (red_reg >= cap)
                        begin
                            res_next   = mk_res(ST_LIMIT, '0, '0, cs_reg, 1'b1);
                            pstat_next = PS_DONE;
                        end
                        else if (13'(tgt) >= rlim)
                        begin
                            res_next   = mk_res(ST_BAD_RULE, '0, '0, cs_reg, 1'b1);
                            pstat_next = PS_DONE;
                        end
                        else
                        begin
                            rule_next  = tgt;
                            rl_raddr   = LAW'(tgt);
                            state_next = S_RLEN;
                        end
                    end
                endcase
            end

            S_RLEN:
            begin
                if (int'(rl_rdata) > MAX_RULE_LEN)
                begin
                    k_next = KW'(MAX_RULE_LEN);
                end
                else
                begin
                    k_next = KW'(rl_rdata);
                end
                state_next = S_POP;
            end

            // pop loop: read top entry and rule symbol k
            S_POP:
            begin
                if (k_reg == '0)
                begin
                    rs_raddr   = rs_addr(rule_reg, 7'd0);
                    state_next = S_GOTOST;
                end
                else if (sp_reg <= SPW'(1))
                begin
                    res_next   = mk_res(ST_MISMATCH, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_POPCMP;
                end
            end

            S_POPCMP:
            begin
                if (stk_rdata[10:0] != rs_rdata)
                begin
                    res_next   = mk_res(ST_MISMATCH, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    sp_next    = spm1;
                    k_next     = k_reg - KW'(1);
                    state_next = S_POP;
                end
            end

            // uncovered state and lhs arrive; issue goto lookup
            S_GOTOST:
            begin
                cs_next  = pst;
                lhs_next = rs_rdata;
                oob_next = (int'(rs_rdata) >= NUM_SYMBOLS);
                tbl_raddr = tbl_addr(pst, rs_rdata);
                if (13'(pst) >= lim)
                begin
                    res_next   = mk_res(ST_BAD_STATE, '0, '0, pst, 1'b1);
                    pstat_next = PS_DONE;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_GOTOLK;
                end
            end

            S_GOTOLK:
            begin
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                if (kind_t'(e[10:9]) == KIND_UNKNOWN)
                begin
                    res_next   = mk_res(ST_UNKNOWN, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                end
                else if (kind_t'(e[10:9]) != KIND_SHIFT)
                begin
                    res_next   = mk_res(ST_NO_TRANS, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                end
                else if (13'(tgt) >= lim)
                begin
                    res_next   = mk_res(ST_BAD_STATE, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                end
                else if (int'(sp_reg) >= STACK_DEPTH)
                begin
                    res_next   = mk_res(ST_LIMIT, '0, '0, cs_reg, 1'b1);
                    pstat_next = PS_DONE;
                end
                else
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {STW'(tgt), lhs_reg};
                    sp_next   = sp_reg + SPW'(1);
                    cs_next   = STW'(tgt);
                    red_next  = red_reg + RDW'(1);
                    res_next  = mk_res(ST_REDUCE, rule_reg, lhs_reg, STW'(tgt), 1'b0);
                    ret_next  = S_PROC;
                end
            end

            // hand one result to the output register
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // stack pointer stays within the stack
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer beyond depth");

    // a push during a parse moves the pointer up by one
    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (stk_we && (state_reg != S_IDLE)) |=> (sp_reg == $past(sp_reg) + SPW'(1)))
        else $error("push did not advance stack pointer");

    // reduction count never passes the limit
    a_red_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(red_reg) <= MAX_REDUCTIONS)
        else $error("reduction count over limit");

    // table sweep writes only empty entries
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (tbl_we && (tbl_wdata == '0)))
        else $error("clear pass wrote a non-empty entry");

endmodule

@@ src/lr1_table_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr1_table_parser
// Table-driven LR(1) shift/reduce recognizer with a streaming interface.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input items: table writes, rule writes, parse start, tokens
//   (s_tuser = mode, s_tlast = last token). m_* returns one result item per
//   shift, reduce, accept, ack or error; m_tlast marks the final result of
//   each input item. cfg_* writes begin_symbol, end_symbol, state_count and
//   rule_count; it is always ready.
//   Sequence: a table or rule write is taken and then acknowledged. A token
//   shift steps through accept, state check, table read and result. Each
//   reduction reads the rule length, pops and checks each rule symbol in
//   turn and then looks up the goto, all under one sequencer. s_tready
//   stays low while an item is at work.
//   Reset: the action table is cleared by a sweep of all NUM_STATES*NUM_SYMBOLS
//   entries (524288 by default) during which no item is taken.
//   A stalled m_tready holds the result register; the sequencer waits at its
//   next result while the register is full.
// ----------------------------------------------------------------------------
module lr1_table_parser #(
    parameter int NUM_STATES     = 256,
    parameter int NUM_SYMBOLS    = 2048,
    parameter int NUM_RULES      = 512,
    parameter int MAX_RULE_LEN   = 16,
    parameter int STACK_DEPTH    = 256,
    parameter int MAX_REDUCTIONS = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[8:0], symbol[19:9], action_kind[21:20], target[30:22],
    // rule_pos[35:31], rule_length[40:36], zero fill
    input  logic [47:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[3:0], rule_number[12:4], lhs_symbol[23:13], state_now[31:24]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import lr1tp_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    res_t  res, out_reg;
    logic  res_valid, res_ready, out_valid_reg;

    // unpack the input item
    assign item.mode        = mode_t'(s_tuser);
    assign item.row         = s_tdata[8:0];
    assign item.symbol      = s_tdata[19:9];
    assign item.action_kind = s_tdata[21:20];
    assign item.target      = s_tdata[30:22];
    assign item.rule_pos    = s_tdata[35:31];
    assign item.rule_length = s_tdata[40:36];
    assign item.last_token  = s_tlast;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_symbol <= 11'd0;
            cfg_reg.end_symbol   <= 11'd1;
            cfg_reg.state_count  <= 9'd256;
            cfg_reg.rule_count   <= 10'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BEGIN: cfg_reg.begin_symbol <= cfg_data;
                REG_END:   cfg_reg.end_symbol   <= cfg_data;
                REG_SCNT:  cfg_reg.state_count  <= cfg_data[8:0];
                REG_RCNT:  cfg_reg.rule_count   <= cfg_data[9:0];
                default:   cfg_reg.begin_symbol <= cfg_data;
            endcase
        end
    end

    lr1tp_engine #(
        .NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS), .NUM_RULES(NUM_RULES),
        .MAX_RULE_LEN(MAX_RULE_LEN), .STACK_DEPTH(STACK_DEPTH),
        .MAX_REDUCTIONS(MAX_REDUCTIONS)
    ) u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(item),
        .cfg(cfg_reg),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.state_now, out_reg.lhs_symbol, out_reg.rule_number,
                       out_reg.status};
    assign m_tlast  = out_reg.last;

endmodule
